// ----- hdl/kfw_pkg.sv -----
// Shared types, constants and helper functions for the FASTA k-mer window generator.
`default_nettype none
package kfw_pkg;

	localparam int MAX_WINDOW_DEF    = 21;
	localparam int MAX_STRIDE_DEF    = 255;
	localparam int POSITION_BITS_DEF = 40;

	localparam int BASES_W     = 63;
	localparam int POS_OUT_W   = 40;
	localparam int LEN_W       = 5;
	localparam int STRIDE_W    = 8;
	localparam int CFG_DATA_W  = 8;
	localparam int CFG_INDEX_W = 1;
	localparam int BYTE_W      = 8;
	localparam int CODE_W      = 3;
	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 104;

	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_STRIDE = 1'b1;

	localparam logic [LEN_W-1:0]    LENGTH_RESET = 5'd21;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 8'd1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [BYTE_W-1:0] CH_HEADER  = 8'h3E;
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_A       = 8'h41;
	localparam logic [BYTE_W-1:0] CH_C       = 8'h43;
	localparam logic [BYTE_W-1:0] CH_G       = 8'h47;
	localparam logic [BYTE_W-1:0] CH_T       = 8'h54;
	localparam logic [BYTE_W-1:0] CH_N       = 8'h4E;
	localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [BYTE_W-1:0] CASE_SHIFT = 8'h20;

	localparam logic [CODE_W-1:0] CODE_A = 3'd0;
	localparam logic [CODE_W-1:0] CODE_C = 3'd1;
	localparam logic [CODE_W-1:0] CODE_G = 3'd2;
	localparam logic [CODE_W-1:0] CODE_T = 3'd3;
	localparam logic [CODE_W-1:0] CODE_N = 3'd4;

	typedef struct packed {
		logic              hit;
		logic [CODE_W-1:0] code;
	} base_lookup_t;

	typedef struct packed {
		logic [BASES_W-1:0]   window;
		logic [LEN_W-1:0]     len;
		logic [POS_OUT_W-1:0] pos;
	} kfw_entry_t;

	function automatic base_lookup_t base_lookup(input logic [BYTE_W-1:0] ch);
		logic [BYTE_W-1:0] up;
		base_lookup_t      res;
		up = (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ? ch - CASE_SHIFT : ch;
		res.hit  = 1'b1;
		res.code = CODE_A;
		case (up)
			CH_A: res.code = CODE_A;
			CH_C: res.code = CODE_C;
			CH_G: res.code = CODE_G;
			CH_T: res.code = CODE_T;
			CH_N: res.code = CODE_N;
			default: res.hit = 1'b0;
		endcase
		return res;
	endfunction

	function automatic logic [CODE_W-1:0] complement(input logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] res;
		case (code)
			CODE_A: res = CODE_T;
			CODE_C: res = CODE_G;
			CODE_G: res = CODE_C;
			CODE_T: res = CODE_A;
			default: res = CODE_N;
		endcase
		return res;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/kfw_front.sv -----
// Front end: byte parsing, header skipping, base window shift register and window scheduling.
`default_nettype none
module kfw_front #(
	parameter int MAX_WINDOW    = kfw_pkg::MAX_WINDOW_DEF,
	parameter int MAX_STRIDE    = kfw_pkg::MAX_STRIDE_DEF,
	parameter int POSITION_BITS = kfw_pkg::POSITION_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [kfw_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [kfw_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [kfw_pkg::BYTE_W-1:0]         in_byte,
	input  wire logic                               in_eos,
	output logic                                    push,
	output kfw_pkg::kfw_entry_t                     push_entry,
	input  wire logic                               queue_full
);

	localparam int WIN_W    = 3 * MAX_WINDOW;
	localparam int FILL_MAX = (MAX_STRIDE > MAX_WINDOW) ? MAX_STRIDE : MAX_WINDOW;
	localparam int FILL_W   = $clog2(FILL_MAX + 1);

	logic [kfw_pkg::LEN_W-1:0]    len_q;
	logic [kfw_pkg::STRIDE_W-1:0] stride_q;
	logic [WIN_W-1:0]             win_q;
	logic [FILL_W-1:0]            fill_q;
	logic [POSITION_BITS-1:0]     pos_q;
	logic                         skip_q;
	logic                         inrec_q;

	logic [kfw_pkg::LEN_W-1:0]            eff_len;
	logic [kfw_pkg::STRIDE_W-1:0]         eff_stride;
	kfw_pkg::base_lookup_t                lk;
	logic                                 accepted;
	logic                                 is_base;
	logic [FILL_W-1:0]                    fill_dec;
	logic                                 complete;
	logic [WIN_W+kfw_pkg::CODE_W-1:0]     win_cat;
	logic [WIN_W-1:0]                     win_shift;
	logic [POSITION_BITS+kfw_pkg::POS_OUT_W-1:0] pos_ext;

	always_comb begin
		if (len_q == '0) begin
			eff_len = kfw_pkg::LEN_W'(1);
		end else if (int'(len_q) > MAX_WINDOW) begin
			eff_len = kfw_pkg::LEN_W'(MAX_WINDOW);
		end else begin
			eff_len = len_q;
		end
		if (stride_q == '0) begin
			eff_stride = kfw_pkg::STRIDE_W'(1);
		end else if (int'(stride_q) > MAX_STRIDE) begin
			eff_stride = kfw_pkg::STRIDE_W'(MAX_STRIDE);
		end else begin
			eff_stride = stride_q;
		end
	end

	assign lk        = kfw_pkg::base_lookup(in_byte);
	assign in_ready  = !queue_full;
	assign accepted  = in_valid && in_ready;
	assign is_base   = !skip_q && (in_byte != kfw_pkg::CH_HEADER) && inrec_q && lk.hit;
	assign fill_dec  = (fill_q == '0) ? '0 : fill_q - FILL_W'(1);
	assign complete  = accepted && is_base && (fill_dec == '0);
	assign win_cat   = {lk.code, win_q};
	assign win_shift = win_cat[WIN_W+kfw_pkg::CODE_W-1:kfw_pkg::CODE_W];
	assign pos_ext   = {{kfw_pkg::POS_OUT_W{1'b0}}, pos_q};

	assign push              = complete;
	assign push_entry.window = kfw_pkg::BASES_W'(win_shift);
	assign push_entry.len    = eff_len;
	assign push_entry.pos    = pos_ext[kfw_pkg::POS_OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= kfw_pkg::LENGTH_RESET;
			stride_q <= kfw_pkg::STRIDE_RESET;
			win_q    <= '0;
			fill_q   <= '0;
			pos_q    <= '0;
			skip_q   <= 1'b0;
			inrec_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kfw_pkg::REG_WINDOW_LENGTH: len_q <= cfg_data[kfw_pkg::LEN_W-1:0];
					kfw_pkg::REG_WINDOW_STRIDE: stride_q <= cfg_data;
					default: ;
				endcase
			end
			if (accepted) begin
				if (skip_q) begin
					if (in_byte == kfw_pkg::CH_NEWLINE) begin
						skip_q <= 1'b0;
					end
				end else if (in_byte == kfw_pkg::CH_HEADER) begin
					skip_q  <= 1'b1;
					inrec_q <= 1'b1;
					win_q   <= '0;
					fill_q  <= FILL_W'(eff_len);
				end else if (is_base) begin
					win_q <= win_shift;
					if (fill_dec == '0) begin
						pos_q  <= pos_q + POSITION_BITS'(eff_stride);
						fill_q <= FILL_W'(eff_stride);
					end else begin
						fill_q <= fill_dec;
					end
				end
				if (in_eos) begin
					win_q   <= '0;
					fill_q  <= '0;
					pos_q   <= '0;
					skip_q  <= 1'b0;
					inrec_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/kfw_queue.sv -----
// Short queue of completed windows between the front and back ends.
`default_nettype none
module kfw_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire kfw_pkg::kfw_entry_t  push_entry,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      empty,
	output kfw_pkg::kfw_entry_t       head
);

	kfw_pkg::kfw_entry_t mem [kfw_pkg::QUEUE_DEPTH];

	logic [kfw_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [kfw_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [kfw_pkg::QCNT_W-1:0] count_q;

	assign full  = (count_q == kfw_pkg::QCNT_W'(kfw_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + kfw_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + kfw_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + kfw_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - kfw_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/kfw_back.sv -----
// Back end: forms forward and reverse-complement windows and drives the output register.
`default_nettype none
module kfw_back #(
	parameter int MAX_WINDOW = kfw_pkg::MAX_WINDOW_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_empty,
	input  wire kfw_pkg::kfw_entry_t               q_head,
	output logic                                   pop,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [kfw_pkg::BASES_W-1:0]            out_bases,
	output logic [kfw_pkg::POS_OUT_W-1:0]          out_pos,
	output logic                                   out_reverse,
	output logic                                   out_last
);

	localparam int WIN_W = 3 * MAX_WINDOW;

	logic                          phase_q;
	logic                          valid_q;
	logic [kfw_pkg::BASES_W-1:0]   bases_q;
	logic [kfw_pkg::POS_OUT_W-1:0] pos_q;
	logic                          reverse_q;

	logic                          load;
	logic [WIN_W-1:0]              win;
	logic [kfw_pkg::LEN_W-1:0]     sh;
	logic [WIN_W-1:0]              fwd;
	logic [WIN_W-1:0]              rev;

	assign win = q_head.window[WIN_W-1:0];
	assign sh  = kfw_pkg::LEN_W'(MAX_WINDOW) - q_head.len;
	assign fwd = win >> (3 * int'(sh));

	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (i < int'(q_head.len)) begin
				rev[3*i +: 3] = kfw_pkg::complement(win[3*(MAX_WINDOW-1-i) +: 3]);
			end else begin
				rev[3*i +: 3] = '0;
			end
		end
	end

	assign load = (!valid_q || out_ready) && !q_empty;
	assign pop  = load && phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= !phase_q;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bases_q   <= kfw_pkg::BASES_W'(phase_q ? rev : fwd);
			pos_q     <= q_head.pos;
			reverse_q <= phase_q;
		end
	end

	assign out_valid   = valid_q;
	assign out_bases   = bases_q;
	assign out_pos     = pos_q;
	assign out_reverse = reverse_q;
	assign out_last    = reverse_q;

endmodule
`default_nettype wire

// ----- hdl/fasta_kmer_window_generator.sv -----
// Top level of the FASTA k-mer window generator.
// Order: the forward result of a completing base passes through the queue and the output
// register; the reverse-complement result follows it.
// Throughput: one byte per cycle while the queue is not full; a completing window yields a
// forward and a reverse-complement output, and its queue slot frees once the reverse is loaded.
// Reset: clears window, counters, queue and output valid; length reads 21, stride 1.
`default_nettype none
module fasta_kmer_window_generator #(
	parameter int MAX_WINDOW    = kfw_pkg::MAX_WINDOW_DEF,
	parameter int MAX_STRIDE    = kfw_pkg::MAX_STRIDE_DEF,
	parameter int POSITION_BITS = kfw_pkg::POSITION_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [kfw_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [kfw_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [kfw_pkg::TDATA_IN_W-1:0]      s_axis_tdata,   // text_byte
	input  wire logic                                s_axis_tlast,   // end_of_stream
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [kfw_pkg::TDATA_OUT_W-1:0]          m_axis_tdata,   // window_bases, window_position
	output logic [0:0]                               m_axis_tuser,   // reverse_strand
	output logic                                     m_axis_tlast    // last_of_pair
);

	logic                          push;
	kfw_pkg::kfw_entry_t           push_entry;
	logic                          full;
	logic                          pop;
	logic                          empty;
	kfw_pkg::kfw_entry_t           head;
	logic [kfw_pkg::BASES_W-1:0]   out_bases;
	logic [kfw_pkg::POS_OUT_W-1:0] out_pos;
	logic                          out_reverse;

	kfw_front #(
		.MAX_WINDOW    (MAX_WINDOW),
		.MAX_STRIDE    (MAX_STRIDE),
		.POSITION_BITS (POSITION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.in_eos     (s_axis_tlast),
		.push       (push),
		.push_entry (push_entry),
		.queue_full (full)
	);

	kfw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.head       (head)
	);

	kfw_back #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (empty),
		.q_head      (head),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_bases   (out_bases),
		.out_pos     (out_pos),
		.out_reverse (out_reverse),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_pos, out_bases};
	assign m_axis_tuser = out_reverse;

endmodule
`default_nettype wire
